@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ design/amst_pkg.sv @@
// ---------------------------------------------------------------------------
// amst_pkg
// Shared types, constants and helpers for the stack traversal core.
// ---------------------------------------------------------------------------
package amst_pkg;

    localparam int NODES   = 8;
    localparam int NODE_W  = 3;
    localparam int COUNT_W = 4;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_START = 1'b1
    } opcode_t;

    typedef struct packed {
        logic              opcode;
        logic [NODE_W-1:0] row_index;
        logic [NODES-1:0]  row_bits;
        logic [NODE_W-1:0] start_node;
    } in_word_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic              last;
    } out_word_t;

    typedef struct packed {
        logic              en;
        logic [NODE_W-1:0] addr;
        logic [NODES-1:0]  data;
    } adj_wr_t;

    typedef struct packed {
        logic              en;
        logic [NODE_W-1:0] addr;
        logic [NODE_W-1:0] data;
    } stk_wr_t;

    // index of the lowest set bit; zero for an empty vector
    function automatic logic [NODE_W-1:0] lowest_bit(input logic [NODES-1:0] bits);
        logic [NODE_W-1:0] idx;
        idx = '0;
        for (int i = NODES - 1; i >= 0; i--) begin
            if (bits[i]) begin
                idx = NODE_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ design/amst_adj_store.sv @@
// ---------------------------------------------------------------------------
// amst_adj_store
// Adjacency row memory, one write and one registered read port. Rows never
// written read as zero.
// ---------------------------------------------------------------------------
module amst_adj_store (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  amst_pkg::adj_wr_t             wr,
    input  logic [amst_pkg::NODE_W-1:0]   rd_addr,
    output logic [amst_pkg::NODES-1:0]    rd_data
);

    logic [amst_pkg::NODES-1:0] mem [amst_pkg::NODES];
    logic [amst_pkg::NODES-1:0] valid_reg;
    logic [amst_pkg::NODES-1:0] rd_data_reg;
    logic                       rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ design/amst_node_stack.sv @@
// ---------------------------------------------------------------------------
// amst_node_stack
// Node stack storage, one write and one registered read port.
// ---------------------------------------------------------------------------
module amst_node_stack (
    input  logic                          aclk,
    input  amst_pkg::stk_wr_t             wr,
    input  logic [amst_pkg::NODE_W-1:0]   rd_addr,
    output logic [amst_pkg::NODE_W-1:0]   rd_data
);

    logic [amst_pkg::NODE_W-1:0] mem [amst_pkg::NODES];
    logic [amst_pkg::NODE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/adjacency_matrix_stack_traversal_core.sv @@
// ---------------------------------------------------------------------------
// adjacency_matrix_stack_traversal_core
// Depth-first traversal over a stored adjacency matrix with a node stack.
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel takes one word per operation. opcode OP_LOAD writes row_bits
//   into the adjacency row row_index and returns nothing. opcode OP_START
//   runs a traversal from start_node and returns one m_ word per reachable
//   node in pop order; the final word has last set.
//   s_ready is high only while no traversal is running. For each popped
//   node a traversal steps through stack read, row read, mark update, one
//   stack write per neighbour it pushes plus one step to find no push left,
//   then the output register load. The single stack and row memory ports
//   set this sequence.
//   When m_ready is low the sequencer holds in its emit step until the
//   output register frees; no word is dropped.
//   Reset clears the adjacency valid bits (all rows read as zero), the
//   visited marks, the stack count and the output valid.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module adjacency_matrix_stack_traversal_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  amst_pkg::in_word_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output amst_pkg::out_word_t  m_data
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_POP   = 6'b000010,
        ST_ROWRD = 6'b000100,
        ST_SCAN  = 6'b001000,
        ST_PUSH  = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t                         state_reg, state_next;
    logic [amst_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [amst_pkg::NODES-1:0]     visited_reg, visited_next;
    logic [amst_pkg::NODES-1:0]     pend_reg, pend_next;
    logic [amst_pkg::NODE_W-1:0]    cur_reg, cur_next;
    logic                           out_valid_reg, out_valid_next;
    amst_pkg::out_word_t            out_word_reg, out_word_next;

    amst_pkg::adj_wr_t              adj_wr;
    amst_pkg::stk_wr_t              stk_wr;
    logic [amst_pkg::NODE_W-1:0]    adj_rd_addr;
    logic [amst_pkg::NODES-1:0]     adj_rd_data;
    logic [amst_pkg::NODE_W-1:0]    stk_rd_addr;
    logic [amst_pkg::NODE_W-1:0]    stk_rd_data;
    logic [amst_pkg::COUNT_W-1:0]   count_dec;
    logic [amst_pkg::NODE_W-1:0]    push_idx;
    logic                           in_fire;
    logic                           out_free;

    amst_adj_store u_adj (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (adj_wr),
        .rd_addr (adj_rd_addr),
        .rd_data (adj_rd_data)
    );

    amst_node_stack u_stack (
        .aclk    (aclk),
        .wr      (stk_wr),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign out_free  = !out_valid_reg || m_ready;
    assign count_dec = count_reg - amst_pkg::COUNT_W'(1);
    assign push_idx  = amst_pkg::lowest_bit(pend_reg);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_word_reg;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        visited_next   = visited_reg;
        pend_next      = pend_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_word_next  = out_word_reg;
        adj_wr         = '0;
        stk_wr         = '0;
        adj_rd_addr    = stk_rd_data;
        stk_rd_addr    = count_dec[amst_pkg::NODE_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_data.opcode == amst_pkg::OP_LOAD) begin
                        adj_wr.en   = (32'(s_data.row_index) < amst_pkg::NODES);
                        adj_wr.addr = s_data.row_index;
                        adj_wr.data = s_data.row_bits;
                    end else if (32'(s_data.start_node) < amst_pkg::NODES) begin
                        visited_next = amst_pkg::NODES'(1) << s_data.start_node;
                        stk_wr.en    = 1'b1;
                        stk_wr.addr  = '0;
                        stk_wr.data  = s_data.start_node;
                        count_next   = amst_pkg::COUNT_W'(1);
                        state_next   = ST_POP;
                    end
                end
            end
            ST_POP: begin
                count_next = count_dec;
                state_next = ST_ROWRD;
            end
            ST_ROWRD: begin
                cur_next   = stk_rd_data;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                pend_next    = adj_rd_data & ~visited_reg;
                visited_next = visited_reg | adj_rd_data;
                state_next   = ST_PUSH;
            end
            ST_PUSH: begin
                if (pend_reg != '0) begin
                    stk_wr.en   = 1'b1;
                    stk_wr.addr = count_reg[amst_pkg::NODE_W-1:0];
                    stk_wr.data = push_idx;
                    count_next  = count_reg + amst_pkg::COUNT_W'(1);
                    pend_next   = pend_reg & ~(amst_pkg::NODES'(1) << push_idx);
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next     = 1'b1;
                    out_word_next.node = cur_reg;
                    out_word_next.last = (count_reg == '0);
                    state_next         = (count_reg == '0) ? ST_IDLE : ST_POP;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            visited_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            visited_reg   <= visited_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg     <= pend_next;
        cur_reg      <= cur_next;
        out_word_reg <= out_word_next;
    end

    `ASSERT_RST(a_count_bound, aclk, aresetn, 32'(count_reg) <= amst_pkg::NODES, "count overflow")
    `ASSERT_RST(a_idle_empty, aclk, aresetn, s_ready |-> (count_reg == '0), "idle, stack nonempty")
    `ASSERT_RST(a_mid_busy, aclk, aresetn, (m_valid && !m_data.last) |-> !s_ready, "idle mid-walk")
    `ASSERT_RST(a_push_marked, aclk, aresetn, (state_reg == ST_PUSH) |-> ((pend_reg & ~visited_reg) == '0), "unmarked push")

endmodule

@@ test/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Checks the stack traversal core against its own depth-first walk model.
// Row loads and start words go in through a bursty sender. The adjacency rows
// are tracked as each word is accepted, and every start is expanded into the
// node order it must produce. The returned words are compared in order while
// the receiver stalls at random, with two long hold-offs.
// ---------------------------------------------------------------------------
module tb_top;

    typedef struct {
        amst_pkg::in_word_t word;
        bit                 drain;
    } stim_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    amst_pkg::in_word_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    amst_pkg::out_word_t m_data;

    stim_t                      stim_q[$];
    amst_pkg::out_word_t        walk_expect[$];
    logic [amst_pkg::NODES-1:0] adj_rows [amst_pkg::NODES];
    int                         err_count  = 0;
    int                         nodes_seen = 0;
    logic                       in_taken   = 1'b0;

    int burst_left = 1;
    int gap_left   = 0;
    int hold_left  = 0;
    int holds_done = 0;
    int hold_at    = 40;
    int rx_mode    = 0;
    int mode_left  = 0;

    adjacency_matrix_stack_traversal_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        err_count++;
    endtask

    task automatic add_load(input int idx, input logic [amst_pkg::NODES-1:0] bits,
                            input bit drain);
        stim_t s;
        s.word.opcode     = amst_pkg::OP_LOAD;
        s.word.row_index  = amst_pkg::NODE_W'(idx);
        s.word.row_bits   = bits;
        s.word.start_node = amst_pkg::NODE_W'($urandom_range(0, amst_pkg::NODES - 1));
        s.drain           = drain;
        stim_q.push_back(s);
    endtask

    task automatic add_start(input int start, input bit drain);
        stim_t s;
        s.word.opcode     = amst_pkg::OP_START;
        s.word.row_index  = amst_pkg::NODE_W'($urandom_range(0, amst_pkg::NODES - 1));
        s.word.row_bits   = amst_pkg::NODES'($urandom);
        s.word.start_node = amst_pkg::NODE_W'(start);
        s.drain           = drain;
        stim_q.push_back(s);
    endtask

    // expand one start into its pop order; last flag on the final node
    function automatic void predict_walk(input logic [amst_pkg::NODE_W-1:0] start);
        logic [amst_pkg::NODES-1:0]  seen;
        logic [amst_pkg::NODE_W-1:0] stk [amst_pkg::NODES];
        logic [amst_pkg::NODE_W-1:0] order [amst_pkg::NODES];
        logic [amst_pkg::NODE_W-1:0] cur;
        amst_pkg::out_word_t         w;
        int                          depth;
        int                          n;
        seen        = '0;
        seen[start] = 1'b1;
        stk[0]      = start;
        depth       = 1;
        n           = 0;
        while (depth > 0) begin
            depth--;
            cur      = stk[depth];
            order[n] = cur;
            n++;
            for (int j = 0; j < amst_pkg::NODES; j++) begin
                if (adj_rows[cur][j] && !seen[j]) begin
                    seen[j]    = 1'b1;
                    stk[depth] = amst_pkg::NODE_W'(j);
                    depth++;
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            w.node = order[i];
            w.last = (i == n - 1);
            walk_expect.push_back(w);
        end
    endfunction

    function automatic logic [amst_pkg::NODES-1:0] pick_row();
        int k;
        k = $urandom_range(0, amst_pkg::NODES - 1);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return amst_pkg::NODES'(1) << k;
            3: return ~(amst_pkg::NODES'(1) << k);
            default: return amst_pkg::NODES'($urandom);
        endcase
    endfunction

    // input side: track the rows and expand starts as words are accepted
    always @(posedge aclk) begin
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            if (s_data.opcode == amst_pkg::OP_LOAD) begin
                adj_rows[s_data.row_index] = s_data.row_bits;
            end else begin
                predict_walk(s_data.start_node);
            end
        end
    end

    // sender
    always @(negedge aclk) begin : sender
        stim_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (stim_q.size() == 0) begin
                s_valid <= 1'b0;
            end else if (stim_q[0].drain && walk_expect.size() != 0) begin
                s_valid <= 1'b0;
            end else begin
                nxt     = stim_q.pop_front();
                s_valid <= 1'b1;
                s_data  <= nxt.word;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 16);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 9: gap_left <= 0;
                        8: gap_left <= $urandom_range(5, 20);
                        default: gap_left <= $urandom_range(1, 4);
                    endcase
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (holds_done < 2 && nodes_seen >= hold_at) begin
            hold_left  <= 400;
            holds_done <= holds_done + 1;
            hold_at    <= hold_at + 500;
            m_ready    <= 1'b0;
        end else if (mode_left == 0) begin
            rx_mode   <= $urandom_range(0, 2);
            mode_left <= $urandom_range(5, 60);
            m_ready   <= 1'b1;
        end else begin
            mode_left <= mode_left - 1;
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // result side
    always @(posedge aclk) begin : node_check
        amst_pkg::out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            nodes_seen <= nodes_seen + 1;
            if (walk_expect.size() == 0) begin
                report_mismatch($sformatf("unexpected word node %0d last %0b",
                                          m_data.node, m_data.last));
            end else begin
                want = walk_expect.pop_front();
                if (m_data.node !== want.node) begin
                    report_mismatch($sformatf("node %0d, want %0d", m_data.node, want.node));
                end
                if (m_data.last !== want.last) begin
                    report_mismatch($sformatf("last %0b on node %0d, want %0b",
                                              m_data.last, m_data.node, want.last));
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        foreach (adj_rows[i]) adj_rows[i] = '0;

        // empty graph: isolated starts at both ends
        add_start(0, 1'b0);
        add_start(amst_pkg::NODES - 1, 1'b0);
        // full row with self loop
        add_load(0, '1, 1'b0);
        add_start(0, 1'b0);
        add_load(amst_pkg::NODES - 1, 8'h81, 1'b0);
        add_start(amst_pkg::NODES - 1, 1'b0);
        add_load(3, '0, 1'b0);
        add_start(3, 1'b0);
        // short chain 5 -> 2 -> 4
        add_load(5, 8'h04, 1'b0);
        add_load(2, 8'h10, 1'b0);
        add_start(5, 1'b1);
        add_load(0, '0, 1'b0);
        add_start(0, 1'b0);
        add_start(amst_pkg::NODES - 1, 1'b0);
        add_load(amst_pkg::NODES - 1, '0, 1'b0);
        add_start(amst_pkg::NODES - 1, 1'b0);

        for (int i = 0; i < 310; i++) begin
            if ($urandom_range(0, 9) < 4) begin
                add_load($urandom_range(0, amst_pkg::NODES - 1), pick_row(), i % 60 == 59);
            end else begin
                add_start($urandom_range(0, amst_pkg::NODES - 1), i % 60 == 59);
            end
        end

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        while (stim_q.size() != 0 || s_valid) @(posedge aclk);
        while (walk_expect.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);

        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ adjacency_matrix_stack_traversal_core.f @@
+incdir+design
design/amst_pkg.sv
design/amst_adj_store.sv
design/amst_node_stack.sv
design/adjacency_matrix_stack_traversal_core.sv
test/tb_top.sv
